// ===== sv/rpad_pkg.sv =====
// ----------------------------------------------------------------------------
// rpad_pkg
// Shared types and constants of the ramped position actuator drive.
// ----------------------------------------------------------------------------
package rpad_pkg;

    localparam int POSITION_BITS = 16;
    localparam int CYCLE_TICKS   = 20;
    localparam int DEADBAND      = 20;
    localparam int CFG_BITS      = 16;
    localparam int TIMER_BITS    = 16;
    localparam int CPOS_BITS     = (CYCLE_TICKS > 1) ? $clog2(CYCLE_TICKS) : 1;

    localparam logic [POSITION_BITS-1:0] DEADBAND_C = POSITION_BITS'(DEADBAND);
    localparam logic [CPOS_BITS-1:0]     CPOS_LAST  = CPOS_BITS'(CYCLE_TICKS - 1);
    localparam logic [TIMER_BITS-1:0]    TIMER_MAX  = {TIMER_BITS{1'b1}};

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        CFG_MIN_POSITION      = 3'd0,
        CFG_MAX_POSITION      = 3'd1,
        CFG_RAMP_UP_MS        = 3'd2,
        CFG_RAMP_DOWN_MS      = 3'd3,
        CFG_UP_INITIAL_DUTY   = 3'd4,
        CFG_UP_STEP_DUTY      = 3'd5,
        CFG_DOWN_INITIAL_DUTY = 3'd6,
        CFG_DOWN_STEP_DUTY    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [POSITION_BITS-1:0] min_position;
        logic [POSITION_BITS-1:0] max_position;
        logic [CFG_BITS-1:0]      ramp_up_ms;
        logic [CFG_BITS-1:0]      ramp_down_ms;
        logic [CFG_BITS-1:0]      up_initial_duty;
        logic [CFG_BITS-1:0]      up_step_duty;
        logic [CFG_BITS-1:0]      down_initial_duty;
        logic [CFG_BITS-1:0]      down_step_duty;
    } t_cfg;

    typedef struct packed {
        logic [POSITION_BITS-1:0] measured_position;
        logic                     new_target_valid;
        logic [POSITION_BITS-1:0] target_position;
        logic                     allow_drive;
    } t_in_word;

    typedef struct packed {
        logic motor_enable;
        logic motor_pull;
        logic motor_release;
        logic solenoid_close;
    } t_out_word;

endpackage

// ===== sv/rpad_cfg.sv =====
// ----------------------------------------------------------------------------
// rpad_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module rpad_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  rpad_pkg::t_cfg_idx         i_cfg_addr,
    input  logic [rpad_pkg::CFG_BITS-1:0] i_cfg_data,
    output rpad_pkg::t_cfg             o_cfg
);

    rpad_pkg::t_cfg r_cfg;
    rpad_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                rpad_pkg::CFG_MIN_POSITION:      n_cfg.min_position      = i_cfg_data;
                rpad_pkg::CFG_MAX_POSITION:      n_cfg.max_position      = i_cfg_data;
                rpad_pkg::CFG_RAMP_UP_MS:        n_cfg.ramp_up_ms        = i_cfg_data;
                rpad_pkg::CFG_RAMP_DOWN_MS:      n_cfg.ramp_down_ms      = i_cfg_data;
                rpad_pkg::CFG_UP_INITIAL_DUTY:   n_cfg.up_initial_duty   = i_cfg_data;
                rpad_pkg::CFG_UP_STEP_DUTY:      n_cfg.up_step_duty      = i_cfg_data;
                rpad_pkg::CFG_DOWN_INITIAL_DUTY: n_cfg.down_initial_duty = i_cfg_data;
                rpad_pkg::CFG_DOWN_STEP_DUTY:    n_cfg.down_step_duty    = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_position      <= '0;
            r_cfg.max_position      <= '1;
            r_cfg.ramp_up_ms        <= 16'd500;
            r_cfg.ramp_down_ms      <= 16'd500;
            r_cfg.up_initial_duty   <= 16'd5;
            r_cfg.up_step_duty      <= 16'd5;
            r_cfg.down_initial_duty <= 16'd5;
            r_cfg.down_step_duty    <= 16'd5;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/rpad_core.sv =====
// ----------------------------------------------------------------------------
// rpad_core
// Per-tick target handling, ramp timer and bridge drive state.
// ----------------------------------------------------------------------------
module rpad_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  rpad_pkg::t_in_word  i_word,
    input  rpad_pkg::t_cfg      i_cfg,
    output rpad_pkg::t_out_word o_word
);

    localparam int PB = rpad_pkg::POSITION_BITS;
    localparam int TB = rpad_pkg::TIMER_BITS;
    localparam int CB = rpad_pkg::CPOS_BITS;
    localparam int MB = TB + rpad_pkg::CFG_BITS + 1;

    logic [PB-1:0]     r_target, n_target;
    rpad_pkg::t_dir    r_dir, n_dir;
    logic [TB-1:0]     r_elapsed, n_elapsed;
    logic [CB-1:0]     r_cpos, n_cpos;
    logic [TB-1:0]     r_cnum, n_cnum;
    logic              r_en, n_en;
    logic              r_pull, n_pull;
    logic              r_rel, n_rel;

    logic [PB-1:0]     pos;
    logic [PB-1:0]     tgt_clamp;
    logic [PB-1:0]     diff_new, diff_held;
    logic              db_new, db_held;
    logic              allow;
    logic              up;
    logic [15:0]       ramp, init, step;
    logic [MB-1:0]     threshold;
    logic              off;

    always_comb begin
        pos   = i_word.measured_position;
        allow = i_word.allow_drive;

        tgt_clamp = i_word.target_position;
        if (tgt_clamp < i_cfg.min_position) tgt_clamp = i_cfg.min_position;
        if (tgt_clamp > i_cfg.max_position) tgt_clamp = i_cfg.max_position;
        diff_new = (pos > tgt_clamp) ? (pos - tgt_clamp) : (tgt_clamp - pos);
        db_new   = diff_new < rpad_pkg::DEADBAND_C;

        n_target  = r_target;
        n_dir     = r_dir;
        n_en      = r_en;
        n_pull    = r_pull;
        n_rel     = r_rel;
        n_elapsed = r_elapsed;
        n_cpos    = r_cpos;
        n_cnum    = r_cnum;

        // advance timer, saturating; cycle position and number track it
        if (r_elapsed != rpad_pkg::TIMER_MAX) begin
            n_elapsed = r_elapsed + 1'b1;
            if (r_cpos == rpad_pkg::CPOS_LAST) begin
                n_cpos = '0;
                n_cnum = r_cnum + 1'b1;
            end else begin
                n_cpos = r_cpos + 1'b1;
            end
        end

        if (i_word.new_target_valid) begin
            n_target = tgt_clamp;
            if (db_new) begin
                n_en = 1'b0;
            end else if (!((tgt_clamp > pos && r_dir == rpad_pkg::DIR_UP) ||
                           (tgt_clamp < pos && r_dir == rpad_pkg::DIR_DOWN))) begin
                n_dir     = (tgt_clamp > pos) ? rpad_pkg::DIR_UP : rpad_pkg::DIR_DOWN;
                n_elapsed = '0;
                n_cpos    = '0;
                n_cnum    = '0;
            end
        end

        if (!allow) n_en = 1'b0;

        diff_held = (pos > n_target) ? (pos - n_target) : (n_target - pos);
        db_held   = diff_held < rpad_pkg::DEADBAND_C;

        up   = n_dir == rpad_pkg::DIR_UP;
        ramp = up ? i_cfg.ramp_up_ms      : i_cfg.ramp_down_ms;
        init = up ? i_cfg.up_initial_duty : i_cfg.down_initial_duty;
        step = up ? i_cfg.up_step_duty    : i_cfg.down_step_duty;
        threshold = MB'(32'(n_cnum) * 32'(step)) + MB'(init);
        off = (n_elapsed <= ramp) && (MB'(n_cpos) > threshold);

        if (n_dir != rpad_pkg::DIR_IDLE) begin
            if (!allow || db_held) begin
                n_en = 1'b0;
            end else begin
                n_pull = pos < n_target;
                n_rel  = !(pos < n_target);
                n_en   = !off;
            end
        end

        o_word.motor_enable   = n_en;
        o_word.motor_pull     = n_pull;
        o_word.motor_release  = n_rel;
        o_word.solenoid_close = allow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_dir     <= rpad_pkg::DIR_IDLE;
            r_elapsed <= '0;
            r_cpos    <= '0;
            r_cnum    <= '0;
            r_en      <= 1'b0;
            r_pull    <= 1'b0;
            r_rel     <= 1'b0;
        end else if (i_step) begin
            r_target  <= n_target;
            r_dir     <= n_dir;
            r_elapsed <= n_elapsed;
            r_cpos    <= n_cpos;
            r_cnum    <= n_cnum;
            r_en      <= n_en;
            r_pull    <= n_pull;
            r_rel     <= n_rel;
        end
    end

endmodule

// ===== sv/ramped_position_actuator_drive_top.sv =====
// ----------------------------------------------------------------------------
// ramped_position_actuator_drive_top
// Ramped H-bridge drive for a position actuator, one word per control tick.
// ----------------------------------------------------------------------------
// Each input word is one control tick and yields exactly one output word.
// A word sits in the input register while the tick logic (clamp, deadband
// compare, one 16x16 duty multiply) runs, and its result is written to the
// output register together with the drive state; the input register refills
// in the same cycle, so one word per clock is sustained while the output
// side takes words. Users must write configuration only while no word is in
// flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module ramped_position_actuator_drive_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rpad_pkg::t_in_word            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rpad_pkg::t_out_word           o_out_data,
    input  logic                          i_cfg_we,
    input  rpad_pkg::t_cfg_idx            i_cfg_addr,
    input  logic [rpad_pkg::CFG_BITS-1:0] i_cfg_data
);

    rpad_pkg::t_cfg      cfg;
    rpad_pkg::t_in_word  r_in;
    logic                r_in_valid;
    rpad_pkg::t_out_word r_out;
    logic                r_out_valid;
    rpad_pkg::t_out_word core_word;
    logic                advance;

    // move a word to the output when the output register is free or drains
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    rpad_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rpad_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_word  (r_in),
        .i_cfg   (cfg),
        .o_word  (core_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
